// ----- src/assert_macros.svh -----
// Assertion helpers shared by the envelope RTL.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_IMPLIES(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: implication");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ----- src/lfe_pkg.sv -----
// Shared types and constants for the LED flicker envelope.
// Used by lfe_divider and led_flicker_envelope; depends on nothing.
package lfe_pkg;

	// Field widths.
	localparam int LEVEL_W   = 8;
	localparam int PHASE_W   = 3;
	localparam int OPCODE_W  = 2;
	localparam int MS_W      = 16;
	localparam int ELAPSED_W = 17;
	localparam int CFG_IDX_W = 4;

	// Shared divider sizing: a ramp dividend is at most 255 * 65535 + 65534.
	localparam int DVD_W  = 25;
	localparam int DVS_W  = MS_W;
	localparam int QUOT_W = LEVEL_W;
	localparam int CNT_W  = 5;

	localparam logic [CNT_W-1:0] RAMP_STEPS = CNT_W'(DVD_W);
	localparam logic [CNT_W-1:0] DRAW_STEPS = CNT_W'(MS_W);

	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	// Opcodes.
	localparam logic [OPCODE_W-1:0] OP_TICK  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_START = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_STOP  = 2'd2;

	// Phase codes.
	localparam logic [PHASE_W-1:0] PH_STOPPED = 3'd0;
	localparam logic [PHASE_W-1:0] PH_IDLE    = 3'd1;
	localparam logic [PHASE_W-1:0] PH_UP      = 3'd2;
	localparam logic [PHASE_W-1:0] PH_HOLD    = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DOWN    = 3'd4;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_LOW  = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_HIGH = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_MIN    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_MAX    = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_MIN    = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_MAX    = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_MIN    = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_MAX    = 4'd7;

	// Register reset values.
	localparam logic [LEVEL_W-1:0] RST_BRIGHT_LOW  = 8'd0;
	localparam logic [LEVEL_W-1:0] RST_BRIGHT_HIGH = 8'd255;
	localparam logic [MS_W-1:0]    RST_IDLE_MIN    = 16'd100;
	localparam logic [MS_W-1:0]    RST_IDLE_MAX    = 16'd1000;
	localparam logic [MS_W-1:0]    RST_RAMP_MIN    = 16'd10;
	localparam logic [MS_W-1:0]    RST_RAMP_MAX    = 16'd100;
	localparam logic [MS_W-1:0]    RST_HOLD_MIN    = 16'd10;
	localparam logic [MS_W-1:0]    RST_HOLD_MAX    = 16'd100;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_WAIT_IN,
		S_LEVEL,
		S_RAMP_DIV,
		S_RAMP_WAIT,
		S_ADVANCE,
		S_DRAW_DIV,
		S_DRAW_WAIT,
		S_RESULT
	} state_t;

	// Request into the shared divider.
	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
		logic [CNT_W-1:0] steps;
	} div_req_t;

	// Result from the shared divider.
	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quotient;
		logic [DVS_W-1:0]  remainder;
	} div_rsp_t;

endpackage

// ----- src/led_flicker_envelope.sv -----
// LED flicker envelope: idle, ramp up, sustain, ramp down with random phase lengths.
// Instantiates lfe_divider; depends on lfe_pkg and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid, in_stall, opcode, random_draw): one item per tick,
//   start or stop. in_stall is low only while the block waits for an item.
//   Output channel (out_valid, out_stall, level, phase): exactly one item per
//   input item, giving the LED level and the phase after that input item.
//   Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): always
//   ready; write only while no item is in flight. Indexes above 7 are ignored.
// Sequencing: stop and unknown opcodes go straight to their result; a start
//   draws a new length in the divider when the range is open; a tick
//   updates the level, divides a ramp level when a ramp of nonzero length
//   runs, and draws a new length when the phase changes.
//   One item is worked on at a time; the single shared restoring divider
//   works one bit per cycle.
// Reset: the envelope is stopped, level 0, all registers at their defaults.
// A stalled result holds its level and phase, and no new item is taken
// until it is delivered.
`include "assert_macros.svh"

module led_flicker_envelope (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [lfe_pkg::OPCODE_W-1:0]    opcode,
	input  logic [lfe_pkg::MS_W-1:0]        random_draw,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lfe_pkg::LEVEL_W-1:0]     level,
	output logic [lfe_pkg::PHASE_W-1:0]     phase,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [lfe_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lfe_pkg::MS_W-1:0]        cfg_data
);

	// Configuration registers.
	logic [lfe_pkg::LEVEL_W-1:0] bright_low_q, bright_high_q;
	logic [lfe_pkg::MS_W-1:0]    idle_min_q, idle_max_q;
	logic [lfe_pkg::MS_W-1:0]    ramp_min_q, ramp_max_q;
	logic [lfe_pkg::MS_W-1:0]    hold_min_q, hold_max_q;

	// Envelope state.
	lfe_pkg::state_t               state_q, state_d;
	logic [lfe_pkg::PHASE_W-1:0]   phase_q;
	logic [lfe_pkg::ELAPSED_W-1:0] elapsed_q;
	logic [lfe_pkg::MS_W-1:0]      duration_q;
	logic [lfe_pkg::LEVEL_W-1:0]   level_q;

	// Item payload and ramp product.
	logic [lfe_pkg::MS_W-1:0]              draw_q;
	logic [lfe_pkg::LEVEL_W+lfe_pkg::MS_W-1:0] prod_q;

	lfe_pkg::div_req_t div_req;
	lfe_pkg::div_rsp_t div_rsp;

	logic                              in_acc;
	logic                              cfg_acc;
	logic                              descending;
	logic [lfe_pkg::LEVEL_W-1:0]       span;
	logic                              rising;
	logic                              in_ramp;
	logic [lfe_pkg::MS_W-1:0]          elapsed_clip;
	logic [lfe_pkg::MS_W-1:0]          ramp_num;
	logic [lfe_pkg::DVD_W-1:0]         ramp_dvd;
	logic [lfe_pkg::MS_W-1:0]          rng_lo, rng_hi;
	logic                              rng_open;
	logic [lfe_pkg::PHASE_W-1:0]       next_phase;
	logic                              phase_over;

	assign in_acc    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	// Ramp arithmetic: span, clipped elapsed count and rounded dividend.
	always_comb begin
		descending   = bright_high_q < bright_low_q;
		span         = descending ? (bright_low_q - bright_high_q)
		                          : (bright_high_q - bright_low_q);
		rising       = phase_q == lfe_pkg::PH_UP;
		in_ramp      = (phase_q == lfe_pkg::PH_UP) || (phase_q == lfe_pkg::PH_DOWN);
		elapsed_clip = (elapsed_q > {1'b0, duration_q}) ? duration_q
		                                                : elapsed_q[lfe_pkg::MS_W-1:0];
		ramp_num     = rising ? elapsed_clip : (duration_q - elapsed_clip);
		ramp_dvd     = {1'b0, prod_q} + (descending
		               ? {{(lfe_pkg::DVD_W-lfe_pkg::MS_W){1'b0}}, duration_q - 1'b1}
		               : lfe_pkg::DVD_W'(0));
	end

	// Duration range of the current phase and the phase that follows it.
	always_comb begin
		case (phase_q)
			lfe_pkg::PH_IDLE: begin
				rng_lo = idle_min_q;
				rng_hi = idle_max_q;
			end
			lfe_pkg::PH_HOLD: begin
				rng_lo = hold_min_q;
				rng_hi = hold_max_q;
			end
			default: begin
				rng_lo = ramp_min_q;
				rng_hi = ramp_max_q;
			end
		endcase
		rng_open   = rng_hi > rng_lo;
		next_phase = (phase_q == lfe_pkg::PH_DOWN) ? lfe_pkg::PH_IDLE : (phase_q + 1'b1);
		phase_over = (phase_q != lfe_pkg::PH_STOPPED) && (elapsed_q > {1'b0, duration_q});
	end

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfe_pkg::S_WAIT_IN;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and divider requests.
	always_comb begin
		state_d          = state_q;
		div_req.start    = 1'b0;
		div_req.dividend = (state_q == lfe_pkg::S_RAMP_DIV) ? ramp_dvd
		                 : {draw_q, {(lfe_pkg::DVD_W-lfe_pkg::MS_W){1'b0}}};
		div_req.divisor  = (state_q == lfe_pkg::S_RAMP_DIV) ? duration_q : (rng_hi - rng_lo);
		div_req.steps    = (state_q == lfe_pkg::S_RAMP_DIV) ? lfe_pkg::RAMP_STEPS
		                                                    : lfe_pkg::DRAW_STEPS;
		case (state_q)
			lfe_pkg::S_WAIT_IN: begin
				if (in_acc) begin
					if (opcode == lfe_pkg::OP_TICK) begin
						state_d = lfe_pkg::S_LEVEL;
					end else if (opcode == lfe_pkg::OP_START) begin
						state_d = lfe_pkg::S_DRAW_DIV;
					end else begin
						state_d = lfe_pkg::S_RESULT;
					end
				end
			end
			lfe_pkg::S_LEVEL: begin
				state_d = (in_ramp && duration_q != '0) ? lfe_pkg::S_RAMP_DIV
				                                        : lfe_pkg::S_ADVANCE;
			end
			lfe_pkg::S_RAMP_DIV: begin
				div_req.start = 1'b1;
				state_d       = lfe_pkg::S_RAMP_WAIT;
			end
			lfe_pkg::S_RAMP_WAIT: begin
				if (div_rsp.done) begin
					state_d = lfe_pkg::S_ADVANCE;
				end
			end
			lfe_pkg::S_ADVANCE: begin
				state_d = phase_over ? lfe_pkg::S_DRAW_DIV : lfe_pkg::S_RESULT;
			end
			lfe_pkg::S_DRAW_DIV: begin
				div_req.start = rng_open;
				state_d       = rng_open ? lfe_pkg::S_DRAW_WAIT : lfe_pkg::S_RESULT;
			end
			lfe_pkg::S_DRAW_WAIT: begin
				if (div_rsp.done) begin
					state_d = lfe_pkg::S_RESULT;
				end
			end
			lfe_pkg::S_RESULT: begin
				if (!out_stall) begin
					state_d = lfe_pkg::S_WAIT_IN;
				end
			end
			default: begin
				state_d = lfe_pkg::S_WAIT_IN;
			end
		endcase
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bright_low_q  <= lfe_pkg::RST_BRIGHT_LOW;
			bright_high_q <= lfe_pkg::RST_BRIGHT_HIGH;
			idle_min_q    <= lfe_pkg::RST_IDLE_MIN;
			idle_max_q    <= lfe_pkg::RST_IDLE_MAX;
			ramp_min_q    <= lfe_pkg::RST_RAMP_MIN;
			ramp_max_q    <= lfe_pkg::RST_RAMP_MAX;
			hold_min_q    <= lfe_pkg::RST_HOLD_MIN;
			hold_max_q    <= lfe_pkg::RST_HOLD_MAX;
		end else if (cfg_acc) begin
			case (cfg_index)
				lfe_pkg::REG_BRIGHT_LOW:  bright_low_q  <= cfg_data[lfe_pkg::LEVEL_W-1:0];
				lfe_pkg::REG_BRIGHT_HIGH: bright_high_q <= cfg_data[lfe_pkg::LEVEL_W-1:0];
				lfe_pkg::REG_IDLE_MIN:    idle_min_q    <= cfg_data;
				lfe_pkg::REG_IDLE_MAX:    idle_max_q    <= cfg_data;
				lfe_pkg::REG_RAMP_MIN:    ramp_min_q    <= cfg_data;
				lfe_pkg::REG_RAMP_MAX:    ramp_max_q    <= cfg_data;
				lfe_pkg::REG_HOLD_MIN:    hold_min_q    <= cfg_data;
				lfe_pkg::REG_HOLD_MAX:    hold_max_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// Envelope state updates, step by step under the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= lfe_pkg::PH_STOPPED;
			elapsed_q  <= '0;
			duration_q <= '0;
			level_q    <= '0;
		end else begin
			case (state_q)
				lfe_pkg::S_WAIT_IN: begin
					if (in_acc) begin
						if (opcode == lfe_pkg::OP_TICK) begin
							if (elapsed_q != lfe_pkg::ELAPSED_MAX) begin
								elapsed_q <= elapsed_q + 1'b1;
							end
						end else if (opcode == lfe_pkg::OP_START) begin
							phase_q   <= lfe_pkg::PH_IDLE;
							elapsed_q <= '0;
						end else if (opcode == lfe_pkg::OP_STOP) begin
							phase_q   <= lfe_pkg::PH_STOPPED;
							elapsed_q <= '0;
						end
					end
				end
				lfe_pkg::S_LEVEL: begin
					case (phase_q)
						lfe_pkg::PH_IDLE: level_q <= bright_low_q;
						lfe_pkg::PH_HOLD: level_q <= bright_high_q;
						lfe_pkg::PH_UP, lfe_pkg::PH_DOWN: begin
							// A zero-length ramp is treated as already complete.
							if (duration_q == '0) begin
								level_q <= rising ? bright_high_q : bright_low_q;
							end
						end
						default: level_q <= '0;
					endcase
				end
				lfe_pkg::S_RAMP_WAIT: begin
					if (div_rsp.done) begin
						level_q <= descending ? (bright_low_q - div_rsp.quotient)
						                      : (bright_low_q + div_rsp.quotient);
					end
				end
				lfe_pkg::S_ADVANCE: begin
					if (phase_over) begin
						phase_q   <= next_phase;
						elapsed_q <= '0;
					end
				end
				lfe_pkg::S_DRAW_DIV: begin
					if (!rng_open) begin
						duration_q <= rng_lo;
					end
				end
				lfe_pkg::S_DRAW_WAIT: begin
					if (div_rsp.done) begin
						duration_q <= rng_lo + div_rsp.remainder;
					end
				end
				default: ;
			endcase
		end
	end

	// Item payload and the ramp product, registered ahead of the divider.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			draw_q <= random_draw;
		end
		if (state_q == lfe_pkg::S_LEVEL) begin
			prod_q <= span * ramp_num;
		end
	end

	lfe_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_stall  = state_q != lfe_pkg::S_WAIT_IN;
	assign out_valid = state_q == lfe_pkg::S_RESULT;
	assign level     = level_q;
	assign phase     = phase_q;

	`ASSERT_IMPLIES(a_ready_no_result, clk, arst_n, !in_stall, !out_valid)
	`ASSERT_NEXT(a_stop_enters_stopped, clk, arst_n, in_acc && opcode == lfe_pkg::OP_STOP, phase_q == lfe_pkg::PH_STOPPED)
	`ASSERT_IMPLIES(a_div_only_in_wait, clk, arst_n, div_rsp.done, state_q == lfe_pkg::S_RAMP_WAIT || state_q == lfe_pkg::S_DRAW_WAIT)

endmodule

// ----- src/lfe_divider.sv -----
// Restoring divider, one quotient bit per cycle, shared by ramp and draw math.
// Depends on lfe_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lfe_divider (
	input  logic              clk,
	input  logic              arst_n,
	input  lfe_pkg::div_req_t req,
	output lfe_pkg::div_rsp_t rsp
);

	logic [lfe_pkg::DVD_W-1:0]  dvd_q;
	logic [lfe_pkg::DVS_W-1:0]  dvs_q;
	logic [lfe_pkg::DVS_W-1:0]  rem_q;
	logic [lfe_pkg::QUOT_W-1:0] quot_q;
	logic [lfe_pkg::CNT_W-1:0]  cnt_q;
	logic                       busy_q;
	logic                       done_q;

	logic [lfe_pkg::DVS_W:0] trial;
	logic [lfe_pkg::DVS_W:0] diff;
	logic                    fits;

	// One step: bring down the next dividend bit and try the subtraction.
	always_comb begin
		trial = {rem_q, dvd_q[lfe_pkg::DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	// Control: step count, busy and a one-cycle done pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q  <= req.steps;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == lfe_pkg::CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder, shifted dividend and low quotient bits.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q  <= req.dividend;
			dvs_q  <= req.divisor;
			rem_q  <= '0;
			quot_q <= '0;
		end else if (busy_q) begin
			dvd_q  <= {dvd_q[lfe_pkg::DVD_W-2:0], 1'b0};
			rem_q  <= fits ? diff[lfe_pkg::DVS_W-1:0] : trial[lfe_pkg::DVS_W-1:0];
			quot_q <= {quot_q[lfe_pkg::QUOT_W-2:0], fits};
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quot_q;
	assign rsp.remainder = rem_q;

	`ASSERT_IMPLIES(a_div_no_restart, clk, arst_n, req.start, !busy_q)
	`ASSERT_IMPLIES(a_div_rem_below, clk, arst_n, done_q, rem_q < dvs_q)
	`ASSERT_IMPLIES(a_div_cnt_live, clk, arst_n, busy_q, cnt_q != '0)

endmodule
